FILE: sv/ctsm_pkg.sv
// ----------------------------------------------------------------------------
// ctsm_pkg
// Shared types and constants of the call timing sample monitor.
// ----------------------------------------------------------------------------
package ctsm_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_QUOTA       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLING_ENABLED = 8'd1;

  localparam logic [31:0] EXIT_QUOTA_RESET = 32'd10000;

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  function_id;
    logic [2:0]  thread_id;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  done_function;
    logic [2:0]  done_thread;
    logic [63:0] elapsed_ticks;
    logic [63:0] shortest;
    logic [63:0] longest;
    logic [63:0] summed_time;
    logic [31:0] thread_calls;
    logic [31:0] all_calls;
    logic        stop_sampling;
    logic [31:0] stops_so_far;
  } out_item_t;

endpackage

FILE: sv/ctsm_front.sv
// ----------------------------------------------------------------------------
// ctsm_front
// Accepts call events, drops those outside the configured index range and
// forwards the rest to the event queue.
// ----------------------------------------------------------------------------
module ctsm_front #(
  parameter int unsigned FUNCTIONS = 256,
  parameter int unsigned THREADS   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctsm_pkg::in_item_t  in_data,
  input  logic                clearing,
  output logic                push_valid,
  input  logic                push_ready,
  output ctsm_pkg::in_item_t  push_data
);
  import ctsm_pkg::*;

  logic in_range;
  logic accept;
  logic dropped_r;

  assign in_range = (32'(in_data.function_id) < FUNCTIONS) &&
                    (32'(in_data.thread_id) < THREADS);

  // Out-of-range events need no queue space, but are held off while the
  // statistics are being cleared like any other transaction.
  assign in_ready   = !clearing && (push_ready || !in_range) && !dropped_r;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && in_range;
  assign push_data  = in_data;

  // A dropped transaction holds in_ready low in the cycle after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropped_r <= 1'b0;
    end else begin
      dropped_r <= accept && !in_range;
    end
  end

endmodule

FILE: sv/ctsm_queue.sv
// ----------------------------------------------------------------------------
// ctsm_queue
// Two-entry event queue between the front end and the statistics engine.
// ----------------------------------------------------------------------------
module ctsm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  ctsm_pkg::in_item_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ctsm_pkg::in_item_t  pop_data
);
  import ctsm_pkg::*;

  in_item_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

FILE: sv/ctsm_back.sv
// ----------------------------------------------------------------------------
// ctsm_back
// Statistics engine: stores entry times and runs the read, compute and write
// sequence of each exit over the per-pair and per-function memories.
// ----------------------------------------------------------------------------
module ctsm_back #(
  parameter int unsigned FUNCTIONS = 256,
  parameter int unsigned THREADS   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  ctsm_pkg::in_item_t  q_data,
  input  logic [31:0]         exit_quota,
  input  logic                sampling_enabled,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output ctsm_pkg::out_item_t out_data
);
  import ctsm_pkg::*;

  localparam int unsigned FN_SLOTS   = (FUNCTIONS < 256) ? FUNCTIONS : 256;
  localparam int unsigned TH_SLOTS   = (THREADS < 8) ? THREADS : 8;
  localparam int unsigned FN_AW      = (FN_SLOTS > 1) ? $clog2(FN_SLOTS) : 1;
  localparam int unsigned TH_AW      = (TH_SLOTS > 1) ? $clog2(TH_SLOTS) : 1;
  localparam int unsigned PAIR_AW    = FN_AW + TH_AW;
  localparam int unsigned PAIR_DEPTH = 1 << PAIR_AW;
  localparam int unsigned FN_DEPTH   = 1 << FN_AW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELAPSED,
    ST_UPDATE,
    ST_WRITE
  } state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  logic [63:0] entry_mem [PAIR_DEPTH];
  logic [31:0] calls_mem [PAIR_DEPTH];
  logic [63:0] min_mem   [PAIR_DEPTH];
  logic [63:0] max_mem   [PAIR_DEPTH];
  logic [63:0] total_mem [PAIR_DEPTH];
  logic [31:0] exits_mem [FN_DEPTH];
  logic [31:0] cas_mem   [FN_DEPTH];
  logic [31:0] stops_mem [FN_DEPTH];

  state_t         state_r;
  logic [PAIR_AW-1:0] clr_cnt_r;
  in_item_t       item_r;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic [63:0] entry_rd_r;
  logic [31:0] calls_rd_r;
  logic [63:0] min_rd_r;
  logic [63:0] max_rd_r;
  logic [63:0] total_rd_r;
  logic [31:0] exits_rd_r;
  logic [31:0] cas_rd_r;
  logic [31:0] stops_rd_r;

  logic [63:0] elapsed_r;
  logic [31:0] calls_new_r;
  logic [31:0] exits_new_r;
  logic [63:0] min_new_r;
  logic [63:0] max_new_r;
  logic [63:0] total_new_r;
  logic [31:0] since_r;

  logic               pop;
  logic               rd_en;
  logic               entry_we;
  logic [PAIR_AW-1:0] head_addr;
  logic [PAIR_AW-1:0] item_addr;
  logic [FN_AW-1:0]   head_fn;
  logic [FN_AW-1:0]   item_fn;
  logic               commit;
  logic               stop;
  logic [31:0]        stops_new;
  logic [31:0]        cas_new;
  logic               stat_we;
  logic [PAIR_AW-1:0] stat_addr;
  logic [FN_AW-1:0]   fn_addr;
  logic [PAIR_AW-1:0] entry_addr;

  assign clearing  = (state_r == ST_CLEAR);
  assign q_ready   = (state_r == ST_IDLE);
  assign pop       = q_valid && q_ready;
  assign rd_en     = pop && (q_data.kind == KIND_EXIT);
  assign entry_we  = clearing || (pop && (q_data.kind == KIND_ENTRY));

  assign head_fn   = q_data.function_id[FN_AW-1:0];
  assign item_fn   = item_r.function_id[FN_AW-1:0];
  assign head_addr = {q_data.thread_id[TH_AW-1:0], head_fn};
  assign item_addr = {item_r.thread_id[TH_AW-1:0], item_fn};

  assign stop      = (since_r >= exit_quota) && sampling_enabled;
  assign stops_new = stop ? sat_inc(stops_rd_r) : stops_rd_r;
  assign cas_new   = stop ? exits_new_r : cas_rd_r;
  assign commit    = (state_r == ST_WRITE) && (!out_valid_r || out_ready);

  assign stat_we    = clearing || commit;
  assign stat_addr  = clearing ? clr_cnt_r : item_addr;
  assign fn_addr    = clearing ? clr_cnt_r[FN_AW-1:0] : item_fn;
  assign entry_addr = clearing ? clr_cnt_r : head_addr;

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_addr] <= clearing ? 64'd0 : q_data.timestamp;
    end
    if (rd_en) begin
      entry_rd_r <= entry_mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      calls_mem[stat_addr] <= clearing ? 32'd0 : calls_new_r;
      min_mem[stat_addr]   <= clearing ? 64'd0 : min_new_r;
      max_mem[stat_addr]   <= clearing ? 64'd0 : max_new_r;
      total_mem[stat_addr] <= clearing ? 64'd0 : total_new_r;
    end
    if (rd_en) begin
      calls_rd_r <= calls_mem[head_addr];
      min_rd_r   <= min_mem[head_addr];
      max_rd_r   <= max_mem[head_addr];
      total_rd_r <= total_mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      exits_mem[fn_addr] <= clearing ? 32'd0 : exits_new_r;
      cas_mem[fn_addr]   <= clearing ? 32'd0 : cas_new;
      stops_mem[fn_addr] <= clearing ? 32'd0 : stops_new;
    end
    if (rd_en) begin
      exits_rd_r <= exits_mem[head_fn];
      cas_rd_r   <= cas_mem[head_fn];
      stops_rd_r <= stops_mem[head_fn];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (rd_en) begin
            item_r  <= q_data;
            state_r <= ST_ELAPSED;
          end
        end
        ST_ELAPSED: begin
          elapsed_r   <= item_r.timestamp - entry_rd_r;
          calls_new_r <= sat_inc(calls_rd_r);
          exits_new_r <= sat_inc(exits_rd_r);
          state_r     <= ST_UPDATE;
        end
        ST_UPDATE: begin
          min_new_r   <= ((min_rd_r == 64'd0) || (elapsed_r < min_rd_r)) ?
                         elapsed_r : min_rd_r;
          max_new_r   <= (elapsed_r > max_rd_r) ? elapsed_r : max_rd_r;
          total_new_r <= total_rd_r + elapsed_r;
          since_r     <= exits_new_r - cas_rd_r;
          state_r     <= ST_WRITE;
        end
        ST_WRITE: begin
          if (commit) begin
            out_data_r.done_function   <= item_r.function_id;
            out_data_r.done_thread     <= item_r.thread_id;
            out_data_r.elapsed_ticks   <= elapsed_r;
            out_data_r.shortest        <= min_new_r;
            out_data_r.longest         <= max_new_r;
            out_data_r.summed_time     <= total_new_r;
            out_data_r.thread_calls    <= calls_new_r;
            out_data_r.all_calls       <= exits_new_r;
            out_data_r.stop_sampling   <= stop;
            out_data_r.stops_so_far    <= stops_new;
            state_r                    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/call_timing_sample_monitor.sv
// ----------------------------------------------------------------------------
// call_timing_sample_monitor
// Hardware call profiler: per-thread, per-function timing statistics of
// function calls with a sampling stop decision per function.
// ----------------------------------------------------------------------------
// After reset the block sweeps its statistics memories to zero, one entry per
// cycle over 2^(clog2(min(FUNCTIONS,256)) + clog2(min(THREADS,8))) entries
// (2048 at the default size), and takes no event until the sweep ends;
// configuration writes are taken throughout. An entry event leaves the
// statistics engine idle and ready for the next event; an exit event runs
// through the read, elapsed, update and write-back steps over the single-port
// statistics memories. A two-entry queue lets events be accepted while the
// engine is busy, and the result register lets the engine work through the
// next exit up to its write-back while the previous result waits to be taken.
module call_timing_sample_monitor #(
  parameter int unsigned FUNCTIONS = 256,
  parameter int unsigned THREADS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ctsm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ctsm_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ctsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ctsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ctsm_pkg::*;

  logic [31:0] exit_quota_r;
  logic        sampling_enabled_r;
  logic        clearing;
  logic        push_valid;
  logic        push_ready;
  in_item_t    push_data;
  logic        q_valid;
  logic        q_ready;
  in_item_t    q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_quota_r       <= EXIT_QUOTA_RESET;
      sampling_enabled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXIT_QUOTA:       exit_quota_r       <= cfg_data;
        CFG_SAMPLING_ENABLED: sampling_enabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ctsm_front #(
    .FUNCTIONS (FUNCTIONS),
    .THREADS   (THREADS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ctsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  ctsm_back #(
    .FUNCTIONS (FUNCTIONS),
    .THREADS   (THREADS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_data           (q_data),
    .exit_quota       (exit_quota_r),
    .sampling_enabled (sampling_enabled_r),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

endmodule
